// ===== rtl/q8d_pkg.sv =====
// Shared constants and types for the Q8_0 block dequantizer.
package q8d_pkg;

	localparam int unsigned BlockQuants = 32;
	localparam logic [5:0] PosLastQuant = 6'd33;
	localparam logic [4:0] HalfExpMax = 5'h1F;
	localparam logic [31:0] CanonNan = 32'h7FC0_0000;
	localparam logic [30:0] SingleInf = 31'h7F80_0000;

	// Decoded request handed from the input stage to the arithmetic stage
	typedef struct packed {
		logic [15:0] scale;
		logic [7:0] quant;
		logic [4:0] index;
		logic last;
	} q8d_req_t;

endpackage

// ===== rtl/q8d_parser.sv =====
// Byte stream parser: collects the half scale and issues one request per quant byte.
module q8d_parser import q8d_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic [7:0] byte_in,
	output logic req_valid,
	output q8d_req_t req
);

	logic [5:0] pos_q;
	logic [15:0] scale_q;
	logic [5:0] pos_c;
	logic [4:0] idx;

	always_comb begin
		pos_c = (pos_q > PosLastQuant) ? PosLastQuant : pos_q;
		idx = 5'(pos_c - 6'd2);
	end

	assign req_valid = in_fire && (pos_q > 6'd1);
	assign req.scale = scale_q;
	assign req.quant = byte_in;
	assign req.index = idx;
	assign req.last = (idx == 5'(BlockQuants - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			scale_q <= '0;
		end else if (in_fire) begin
			if (pos_q == 6'd0) begin
				scale_q[7:0] <= byte_in;
				pos_q <= 6'd1;
			end else if (pos_q == 6'd1) begin
				scale_q[15:8] <= byte_in;
				pos_q <= 6'd2;
			end else begin
				pos_q <= req.last ? 6'd0 : pos_c + 6'd1;
			end
		end
	end

endmodule

// ===== rtl/q8d_mul.sv =====
// Exact half-scale times signed byte product, formatted as IEEE single.
module q8d_mul import q8d_pkg::*; (
	input logic [15:0] scale,
	input logic [7:0] quant,
	output logic [31:0] value
);

	logic hsign;
	logic [4:0] hexp;
	logic [9:0] hmant;
	logic [7:0] qmag;
	logic sign;
	logic [10:0] m0;
	logic [17:0] m;
	logic [4:0] p;
	logic [7:0] bexp;
	logic [40:0] sh;

	always_comb begin
		hsign = scale[15];
		hexp = scale[14:10];
		hmant = scale[9:0];
		qmag = quant[7] ? 8'(~quant + 8'd1) : quant;
		sign = hsign ^ quant[7];
		m0 = (hexp == 5'd0) ? {1'b0, hmant} : {1'b1, hmant};
		m = 18'(m0) * 18'(qmag);
		p = '0;
		for (int i = 0; i < 18; i++) begin
			if (m[i]) p = 5'(i);
		end
		// exponent: p + e2 + 127, e2 = -24 subnormal else hexp - 25
		if (hexp == 5'd0) bexp = 8'(p) + 8'd103;
		else bexp = 8'(p) + 8'(hexp) + 8'd102;
		sh = 41'(m) << (5'd23 - p);
		if (hexp == HalfExpMax) begin
			if (hmant != '0 || qmag == '0) value = CanonNan;
			else value = {sign, SingleInf};
		end else if (m == '0) begin
			value = {sign, 31'd0};
		end else begin
			value = {sign, bexp, sh[22:0]};
		end
	end

endmodule

// ===== rtl/q8_0_block_dequantizer_core.sv =====
// Q8_0 block dequantizer top level: parser, product stage and output register.
// The result of an accepted quant byte is registered and appears on the outputs in the next cycle.
// Throughput: one byte per cycle while the output is not stalled; scale bytes give no result.
// The output register is refilled in the same cycle it is drained.
// Reset clears the byte position, the scale and the output valid.
module q8_0_block_dequantizer_core import q8d_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] byte_in,
	output logic out_valid,
	input logic out_ready,
	output logic [31:0] value_bits,
	output logic [4:0] element_index,
	output logic last_in_block
);

	logic in_fire;
	logic req_valid;
	q8d_req_t req;
	logic [31:0] value;

	assign in_ready = !out_valid || out_ready;
	assign in_fire = in_valid && in_ready;

	q8d_parser u_parser (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .byte_in(byte_in),
		.req_valid(req_valid), .req(req)
	);

	q8d_mul u_mul (.scale(req.scale), .quant(req.quant), .value(value));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid) begin
			value_bits <= value;
			element_index <= req.index;
			last_in_block <= req.last;
		end
	end

endmodule

// ===== rtl/q8d_checker.sv =====
// Port-level checker for the Q8_0 dequantizer, bound to the top level.
module q8d_checker import q8d_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [4:0] element_index,
	input logic last_in_block
);

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_in_block == (element_index == 5'd31)))
		else $error("last flag mismatch");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("accepted while stalled");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(element_index)))
		else $error("result dropped");

endmodule

bind q8_0_block_dequantizer_core q8d_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .element_index(element_index), .last_in_block(last_in_block)
);
